// ===== design/assert_macros.svh =====
// Assertion macros used by the RTL of the deframer.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("assertion failed");

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/rfd_pkg.sv =====
// Types and constants of the radio frame deframer.
// No dependencies.
package rfd_pkg;

  localparam int unsigned NumChannels = 16;
  localparam int unsigned FlagByte    = 33;
  localparam int unsigned LostBit     = 2;
  localparam int unsigned FailsafeBit = 3;
  localparam int unsigned ApbAddrW    = 3;
  localparam int unsigned ApbDataW    = 32;

  // register word index on the APB port
  localparam logic RegHeader = 1'b0;

  localparam logic [7:0] HeaderReset = 8'h0F;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_CHK_RD,
    ST_CHK_CMP,
    ST_FLG_RD,
    ST_FLG_CAP,
    ST_HI_RD,
    ST_HI_CAP,
    ST_LO_RD,
    ST_LO_CAP,
    ST_EMIT
  } rfd_state_e;

endpackage

// ===== design/rfd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rfd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 35
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/radio_frame_deframer_core.sv =====
// Serial frame deframer: byte window in a RAM, header resync and channel unpack.
// Depends on rfd_pkg, rfd_ram and assert_macros.svh.
//
// Received bytes go into a circular window of FRAME_LEN bytes held in one RAM
// with a single registered read port; every read of the window goes through
// that port, and every access through one shared modulo-FRAME_LEN adder,
// under a small sequencer. rx_ready_o is high only while the sequencer is idle.
// A byte that leaves the window short of a full frame is written, then the
// resync scan reads and compares the front byte and drops it if it is not the
// header, until a header byte is found or the window is empty. A byte that
// fills the window but fails the frame check has its header read, then the
// check byte read and compared, and the front byte dropped. A byte that
// completes a valid frame goes through scan and check, a flag byte read, then
// for each of the 16 channel results two RAM reads and one load of the output
// register, where the load waits while the output side stalls. A result held
// in the output register does not block the next input byte. The header byte is
// programmed through the APB port at word 0 (reset 0x0F); write it only while the block is idle.
`include "assert_macros.svh"

module radio_frame_deframer_core #(
  parameter int unsigned FRAME_LEN = 35
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // APB configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rfd_pkg::ApbAddrW-1:0] paddr,
  input  logic [rfd_pkg::ApbDataW-1:0] pwdata,
  output logic [rfd_pkg::ApbDataW-1:0] prdata,
  output logic                         pready,
  // byte input
  input  logic                         rx_valid_i,
  output logic                         rx_ready_o,
  input  logic [7:0]                   rx_byte_i,
  // channel results
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [3:0]                   channel_index_o,
  output logic [15:0]                  channel_value_o,
  output logic                         link_lost_o,
  output logic                         failsafe_o,
  output logic                         last_channel_o
);

  import rfd_pkg::*;

  localparam int unsigned IdxW  = $clog2(FRAME_LEN);
  localparam int unsigned FillW = $clog2(FRAME_LEN + 1);

  localparam logic [IdxW-1:0]  OffCheck = IdxW'(FRAME_LEN - 2);
  localparam logic [IdxW-1:0]  OffFlag  = IdxW'(FlagByte);
  localparam logic [IdxW-1:0]  OffOne   = IdxW'(1);
  localparam logic [IdxW-1:0]  OffZero  = '0;
  localparam logic [FillW-1:0] FillFull = FillW'(FRAME_LEN);

  rfd_state_e state_q, state_d;

  logic [7:0]       header_q, header_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [IdxW-1:0]  head_q, head_d;
  logic [IdxW-1:0]  off_q, off_d;
  logic [3:0]       ch_q, ch_d;
  logic [1:0]       flags_q, flags_d;
  logic [7:0]       hi_q, hi_d;
  logic [7:0]       lo_q, lo_d;

  logic             out_valid_q, out_valid_d;
  logic [3:0]       out_idx_q, out_idx_d;
  logic [15:0]      out_val_q, out_val_d;
  logic             out_lost_q, out_lost_d;
  logic             out_fs_q, out_fs_d;
  logic             out_last_q, out_last_d;

  logic             rx_xfer, out_xfer, cfg_wr;
  logic             out_free;

  // shared address unit: (head + offset) mod FRAME_LEN, both operands < FRAME_LEN
  logic [IdxW-1:0]  au_off;
  logic [IdxW:0]    au_sum;
  logic [IdxW-1:0]  au_res;

  logic             ram_we;
  logic [7:0]       ram_rdata;

  // ---------------------------------------------------------------------------
  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    header_d = header_q;
    if (cfg_wr && (paddr[2] == RegHeader)) begin
      header_d = pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == RegHeader) begin
      prdata = {{(ApbDataW-8){1'b0}}, header_q};
    end
  end

  // ---------------------------------------------------------------------------
  // handshakes
  assign rx_ready_o = (state_q == ST_IDLE);
  assign rx_xfer    = rx_valid_i && rx_ready_o;
  assign out_xfer   = out_valid_q && out_ready_i;
  assign out_free   = !out_valid_q || out_ready_i;

  // ---------------------------------------------------------------------------
  // address unit
  always_comb begin
    au_sum = {1'b0, head_q} + {1'b0, au_off};
    if (au_sum >= (IdxW+1)'(FRAME_LEN)) begin
      au_sum = au_sum - (IdxW+1)'(FRAME_LEN);
    end
    au_res = au_sum[IdxW-1:0];
  end

  rfd_ram #(
    .Width(8),
    .Depth(FRAME_LEN)
  ) u_window (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(au_res),
    .wdata_i(rx_byte_i),
    .raddr_i(au_res),
    .rdata_o(ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (rx_xfer) state_d = ST_SCAN_RD;
      end
      ST_SCAN_RD: begin
        state_d = (fill_q == '0) ? ST_IDLE : ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        if (ram_rdata != header_q) begin
          state_d = ST_SCAN_RD;
        end else if (fill_q == FillFull) begin
          state_d = ST_CHK_RD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_CHK_RD:   state_d = ST_CHK_CMP;
      ST_CHK_CMP:  state_d = (ram_rdata[7:4] != 4'h0) ? ST_IDLE : ST_FLG_RD;
      ST_FLG_RD:   state_d = ST_FLG_CAP;
      ST_FLG_CAP:  state_d = ST_HI_RD;
      ST_HI_RD:    state_d = ST_HI_CAP;
      ST_HI_CAP:   state_d = ST_LO_RD;
      ST_LO_RD:    state_d = ST_LO_CAP;
      ST_LO_CAP:   state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_d = (ch_q == 4'(NumChannels - 1)) ? ST_IDLE : ST_HI_RD;
        end
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // datapath control
  always_comb begin
    au_off      = OffZero;
    ram_we      = 1'b0;
    fill_d      = fill_q;
    head_d      = head_q;
    off_d       = off_q;
    ch_d        = ch_q;
    flags_d     = flags_q;
    hi_d        = hi_q;
    lo_d        = lo_q;
    out_valid_d = out_xfer ? 1'b0 : out_valid_q;
    out_idx_d   = out_idx_q;
    out_val_d   = out_val_q;
    out_lost_d  = out_lost_q;
    out_fs_d    = out_fs_q;
    out_last_d  = out_last_q;

    case (state_q)
      ST_IDLE: begin
        // fill < FRAME_LEN here, so it fits the offset width
        au_off = fill_q[IdxW-1:0];
        if (rx_xfer) begin
          ram_we = 1'b1;
          fill_d = fill_q + FillW'(1);
        end
      end
      ST_SCAN_RD: begin
        au_off = OffZero;
      end
      ST_SCAN_CMP: begin
        au_off = OffOne;
        if (ram_rdata != header_q) begin
          head_d = au_res;
          fill_d = fill_q - FillW'(1);
        end
      end
      ST_CHK_RD: begin
        au_off = OffCheck;
      end
      ST_CHK_CMP: begin
        au_off = OffOne;
        if (ram_rdata[7:4] != 4'h0) begin
          head_d = au_res;
          fill_d = fill_q - FillW'(1);
        end
      end
      ST_FLG_RD: begin
        au_off = OffFlag;
      end
      ST_FLG_CAP: begin
        flags_d = {ram_rdata[FailsafeBit], ram_rdata[LostBit]};
        off_d   = OffOne;
        ch_d    = '0;
      end
      ST_HI_RD: begin
        au_off = off_q;
      end
      ST_HI_CAP: begin
        hi_d  = ram_rdata;
        off_d = off_q + OffOne;
      end
      ST_LO_RD: begin
        au_off = off_q;
      end
      ST_LO_CAP: begin
        lo_d  = ram_rdata;
        off_d = off_q + OffOne;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_idx_d   = ch_q;
          out_val_d   = {hi_q, lo_q};
          out_lost_d  = flags_q[0];
          out_fs_d    = flags_q[1];
          out_last_d  = (ch_q == 4'(NumChannels - 1));
          ch_d        = ch_q + 4'd1;
          if (ch_q == 4'(NumChannels - 1)) begin
            fill_d = '0;
          end
        end
      end
      default: begin
        au_off = OffZero;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      header_q    <= HeaderReset;
      fill_q      <= '0;
      head_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      header_q    <= header_d;
      fill_q      <= fill_d;
      head_q      <= head_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    off_q      <= off_d;
    ch_q       <= ch_d;
    flags_q    <= flags_d;
    hi_q       <= hi_d;
    lo_q       <= lo_d;
    out_idx_q  <= out_idx_d;
    out_val_q  <= out_val_d;
    out_lost_q <= out_lost_d;
    out_fs_q   <= out_fs_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o     = out_valid_q;
  assign channel_index_o = out_idx_q;
  assign channel_value_o = out_val_q;
  assign link_lost_o     = out_lost_q;
  assign failsafe_o      = out_fs_q;
  assign last_channel_o  = out_last_q;

  // ---------------------------------------------------------------------------
  // assertions
  `ASSERT_ALWAYS(a_fill_bound, fill_q <= FillFull)
  `ASSERT_ALWAYS(a_head_bound, {1'b0, head_q} < (IdxW+1)'(FRAME_LEN))
  `ASSERT_NEXT(a_push_grows, rx_xfer, fill_q == $past(fill_q) + FillW'(1))
  `ASSERT_NEXT(a_last_empties, (state_q == ST_EMIT) && out_free && out_last_d,
               (fill_q == '0) && (state_q == ST_IDLE))

endmodule

// ===== bench/tb.sv =====
// Testbench for radio_frame_deframer_core: byte stream in, channel results out.
// Depends on rfd_pkg and the core RTL; checks against a built-in deframing model.
module tb;
  import rfd_pkg::*;

  localparam int unsigned FRAME_LEN    = 35;
  localparam int unsigned WinIdxW      = $clog2(FRAME_LEN);
  localparam int unsigned SettleCycles = 120;
  localparam int unsigned StallLimit   = 5000;
  localparam int unsigned PhaseBytes   = 10;

  typedef struct packed {
    logic [3:0]  channel_index;
    logic [15:0] channel_value;
    logic        link_lost;
    logic        failsafe;
    logic        last_channel;
  } chan_result_t;

  // one directed row: optional header write, then junk bytes and a frame (possibly cut short)
  typedef struct packed {
    logic        do_write;
    logic [7:0]  new_header;
    logic [3:0]  junk;
    logic [7:0]  fill;
    logic        rand_fill;
    logic [7:0]  flag;
    logic [6:0]  len;
    logic        typed;
    logic [15:0] t_value;
    logic        t_lost;
    logic        t_fs;
  } dir_row_t;

  localparam dir_row_t DirTable [11] = '{
    '{1'b0, 8'h00, 4'd0, 8'h00, 1'b0, 8'h00, 7'd35, 1'b1, 16'h0000, 1'b0, 1'b0},
    '{1'b0, 8'h00, 4'd0, 8'hFF, 1'b0, 8'h0C, 7'd35, 1'b1, 16'hFFFF, 1'b1, 1'b1},
    '{1'b0, 8'h00, 4'd3, 8'hA5, 1'b0, 8'h04, 7'd35, 1'b1, 16'hA5A5, 1'b1, 1'b0},
    '{1'b0, 8'h00, 4'd0, 8'h5A, 1'b0, 8'h08, 7'd35, 1'b1, 16'h5A5A, 1'b0, 1'b1},
    // check fails on the flag byte nibble
    '{1'b0, 8'h00, 4'd0, 8'h00, 1'b1, 8'h10, 7'd35, 1'b0, 16'h0000, 1'b0, 1'b0},
    // header value all through the payload, then a failed check
    '{1'b0, 8'h00, 4'd0, 8'h0F, 1'b0, 8'hF3, 7'd35, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{1'b1, 8'h00, 4'd2, 8'h00, 1'b1, 8'h0A, 7'd35, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{1'b1, 8'hFF, 4'd0, 8'hFF, 1'b0, 8'h0F, 7'd35, 1'b0, 16'h0000, 1'b0, 1'b0},
    // partial frame left in the window across a header change
    '{1'b0, 8'h00, 4'd0, 8'h00, 1'b1, 8'h00, 7'd10, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{1'b1, 8'h12, 4'd0, 8'h00, 1'b1, 8'h06, 7'd35, 1'b0, 16'h0000, 1'b0, 1'b0},
    '{1'b1, HeaderReset, 4'd0, 8'h00, 1'b1, 8'h03, 7'd35, 1'b0, 16'h0000, 1'b0, 1'b0}
  };

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;
  logic                rx_valid_i;
  logic                rx_ready_o;
  logic [7:0]          rx_byte_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [3:0]          channel_index_o;
  logic [15:0]         channel_value_o;
  logic                link_lost_o;
  logic                failsafe_o;
  logic                last_channel_o;

  radio_frame_deframer_core #(.FRAME_LEN(FRAME_LEN)) DUT (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .rx_valid_i, .rx_ready_o, .rx_byte_i,
    .out_valid_o, .out_ready_i,
    .channel_index_o, .channel_value_o, .link_lost_o, .failsafe_o, .last_channel_o
  );

  // model state
  logic [7:0]   win_mem [FRAME_LEN];
  int unsigned  win_fill;
  int unsigned  win_head;
  logic [7:0]   cur_header;
  chan_result_t pending_channels [$];

  bit          typed_on;
  logic [15:0] typed_value;
  logic        typed_lost;
  logic        typed_fs;

  bit          steady;
  int unsigned errors;
  int unsigned bytes_sent;
  int unsigned stall_cycles;

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  function automatic logic [7:0] win_at(input int unsigned ofs);
    return win_mem[WinIdxW'((win_head + ofs) % FRAME_LEN)];
  endfunction

  function automatic void drop_front();
    if (win_fill != 0) begin
      win_head = (win_head + 1) % FRAME_LEN;
      win_fill--;
    end
  endfunction

  function automatic void deframe_byte(input logic [7:0] b);
    chan_result_t r;
    logic [7:0]   flags;
    if (win_fill >= FRAME_LEN) drop_front();
    win_mem[WinIdxW'((win_head + win_fill) % FRAME_LEN)] = b;
    win_fill++;
    while (win_fill > 0 && win_at(0) != cur_header) drop_front();
    if (win_fill < FRAME_LEN) return;
    if (win_at(0) != cur_header || (win_at(FRAME_LEN - 2) & 8'hF0) != 8'h00) begin
      drop_front();
      return;
    end
    flags = win_at(FlagByte);
    for (int i = 0; i < NumChannels; i++) begin
      r.channel_index = 4'(i);
      r.channel_value = {win_at(2 * i + 1), win_at(2 * i + 2)};
      r.link_lost     = flags[LostBit];
      r.failsafe      = flags[FailsafeBit];
      r.last_channel  = (i == NumChannels - 1);
      if (typed_on) begin
        r.channel_value = typed_value;
        r.link_lost     = typed_lost;
        r.failsafe      = typed_fs;
      end
      pending_channels.push_back(r);
    end
    win_fill = 0;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    while (!steady && $urandom_range(0, 99) < 10) begin
      rx_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    rx_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!rx_ready_o);
    deframe_byte(b);
    bytes_sent++;
  endtask

  task automatic send_frame(input int unsigned junk, input bit rand_fill,
                            input logic [7:0] fill, input logic [7:0] flag,
                            input int unsigned len);
    logic [7:0] frame [FRAME_LEN];
    logic [7:0] j;
    frame[0] = cur_header;
    for (int k = 1; k < FRAME_LEN; k++) begin
      frame[WinIdxW'(k)] = rand_fill ? 8'($urandom) : fill;
    end
    frame[WinIdxW'(FlagByte)] = flag;
    for (int k = 0; k < junk; k++) begin
      do j = 8'($urandom); while (j == cur_header);
      send_byte(j);
    end
    for (int k = 0; k < len; k++) send_byte(frame[WinIdxW'(k)]);
  endtask

  // drain all results, then give a trailing scan time to finish
  task automatic settle();
    rx_valid_i <= 1'b0;
    while (pending_channels.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_header(input logic [7:0] h);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {RegHeader, 2'b00};
    pwdata  <= ApbDataW'(h);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_header = h;
  endtask

  always @(posedge clk_i) begin : result_check
    chan_result_t got;
    chan_result_t want;
    out_ready_i <= steady || ($urandom_range(0, 99) >= 10);
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {channel_index_o, channel_value_o, link_lost_o, failsafe_o, last_channel_o};
      if (pending_channels.size() == 0) begin
        $display("%0t: unexpected result idx=%0d val=%h lost=%b fs=%b last=%b", $time,
                 got.channel_index, got.channel_value, got.link_lost, got.failsafe,
                 got.last_channel);
        errors++;
      end else begin
        want = pending_channels[0];
        pending_channels.delete(0);
        if (got !== want) begin
          $display("%0t: mismatch expected idx=%0d val=%h lost=%b fs=%b last=%b", $time,
                   want.channel_index, want.channel_value, want.link_lost, want.failsafe,
                   want.last_channel);
          $display("%0t:          actual   idx=%0d val=%h lost=%b fs=%b last=%b", $time,
                   got.channel_index, got.channel_value, got.link_lost, got.failsafe,
                   got.last_channel);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (rx_valid_i && rx_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    dir_row_t    row;
    logic [7:0]  h;
    int unsigned phase_start;
    int unsigned pick;
    rst_ni       <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    rx_valid_i   <= 1'b0;
    rx_byte_i    <= '0;
    errors       = 0;
    bytes_sent   = 0;
    steady       = 1'b0;
    typed_on     = 1'b0;
    win_fill     = 0;
    win_head     = 0;
    cur_header   = HeaderReset;
    for (int k = 0; k < FRAME_LEN; k++) win_mem[WinIdxW'(k)] = 8'h00;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int n = 0; n < $size(DirTable); n++) begin
      row = DirTable[n];
      if (row.do_write) begin
        settle();
        write_header(row.new_header);
      end
      typed_on    = row.typed;
      typed_value = row.t_value;
      typed_lost  = row.t_lost;
      typed_fs    = row.t_fs;
      send_frame(32'(row.junk), row.rand_fill, row.fill, row.flag, 32'(row.len));
      typed_on = 1'b0;
    end

    // random phases, each under its own header value; phase 1 runs without idling
    for (int p = 0; p < 3; p++) begin
      case (p)
        0: h = 8'h00;
        1: h = 8'hFF;
        default: h = 8'($urandom);
      endcase
      settle();
      write_header(h);
      steady = (p == 1);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PhaseBytes) begin
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
          send_frame(($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : 0, 1'b1, 8'h00,
                     8'($urandom_range(0, 15)), FRAME_LEN);
        end else if (pick < 75) begin
          send_frame(0, 1'b1, 8'h00, {4'($urandom_range(1, 15)), 4'($urandom)}, FRAME_LEN);
        end else if (pick < 85) begin
          send_frame(0, 1'b1, 8'h00, 8'($urandom_range(0, 15)),
                     $urandom_range(1, FRAME_LEN - 1));
        end else begin
          repeat ($urandom_range(1, 8)) send_byte(8'($urandom));
        end
      end
      steady = 1'b0;
    end

    settle();
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/rfd_pkg.sv
design/rfd_ram.sv
design/radio_frame_deframer_core.sv
bench/tb.sv
